/* rtl/core/ukf_pkg.sv */
`default_nettype none

package ukf_pkg;

   localparam int STATUS_BITS = 3;

   localparam logic [STATUS_BITS-1:0] ST_ENQ   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_DEQ   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_UNDER = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_OVER  = 3'd4;

   typedef struct packed {
      logic start;      // latch request, arm the key scan at head
      logic scan_step;  // check one stored key against the request key
      logic finish;     // commit the request and load the response
   } cmd_type;

   typedef struct packed {
      logic scan_hit;   // current stored key matches
      logic scan_end;   // no stored keys left to check
   } stat_type;

endpackage

`default_nettype wire

/* rtl/core/unique_key_fifo.sv */
`default_nettype none

// FIFO of key/data pairs that rejects an enqueue whose key is already stored.
// One request in flight at a time. An enqueue scans the stored keys one per
// cycle through the single read port of the key store, oldest first, stopping
// early when a duplicate is found. The response register lets the next request
// be accepted while a response waits; that request finishes once the response
// is taken. Enqueue into a full queue reports overflow unless its key is
// already stored, which reports duplicate; dequeue from an empty queue reports
// underflow; none of these changes the queue.

module unique_key_fifo #(
   parameter int DEPTH     = 16,
   parameter int KEY_BITS  = 16,
   parameter int DATA_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_op,
   input  wire logic        [KEY_BITS-1:0]          req_in_key,
   input  wire logic signed [DATA_BITS-1:0]         req_in_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [ukf_pkg::STATUS_BITS-1:0]     rsp_status,
   output      logic        [KEY_BITS-1:0]          rsp_out_key,
   output      logic signed [DATA_BITS-1:0]         rsp_out_data,
   output      logic        [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output      logic                                rsp_is_empty
);

   ukf_pkg::cmd_type  cmd;
   ukf_pkg::stat_type stat;

   ukf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ukf_dpath #(
      .DEPTH     (DEPTH),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_in_key    (req_in_key),
      .req_in_data   (req_in_data),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_data  (rsp_out_data),
      .rsp_occupancy (rsp_occupancy),
      .rsp_is_empty  (rsp_is_empty)
   );

endmodule

`default_nettype wire

/* rtl/core/ukf_ctrl.sv */
`default_nettype none

module ukf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic             req_op,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ukf_pkg::cmd_type cmd,
   input  wire ukf_pkg::stat_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.start     = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.finish    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = req_op ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ukf_dpath.sv */
`default_nettype none

module ukf_dpath #(
   parameter int DEPTH     = 16,
   parameter int KEY_BITS  = 16,
   parameter int DATA_BITS = 32,
   parameter int PTR_W     = $clog2(DEPTH),
   parameter int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_op,
   input  wire logic        [KEY_BITS-1:0]   req_in_key,
   input  wire logic signed [DATA_BITS-1:0]  req_in_data,
   input  wire ukf_pkg::cmd_type             cmd,
   output      ukf_pkg::stat_type            stat,
   output      logic [ukf_pkg::STATUS_BITS-1:0] rsp_status,
   output      logic        [KEY_BITS-1:0]   rsp_out_key,
   output      logic signed [DATA_BITS-1:0]  rsp_out_data,
   output      logic        [CNT_W-1:0]      rsp_occupancy,
   output      logic                         rsp_is_empty
);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [KEY_BITS-1:0]  key_mem_ff  [DEPTH];
   logic [DATA_BITS-1:0] data_mem_ff [DEPTH];

   logic [PTR_W-1:0]     head_ff, head_in, tail_ff, tail_in, scan_ptr_ff, rd_addr;
   logic [CNT_W-1:0]     count_ff, count_in, left_ff;
   logic [KEY_BITS-1:0]  rd_key_ff, key_ff;
   logic [DATA_BITS-1:0] rd_data_ff, data_ff;
   logic                 op_ff, dup_ff, mem_we;

   logic [ukf_pkg::STATUS_BITS-1:0] status_in;
   logic [KEY_BITS-1:0]             out_key_in;
   logic [DATA_BITS-1:0]            out_data_in;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign stat.scan_end = (left_ff == '0);
   assign stat.scan_hit = !stat.scan_end && (rd_key_ff == key_ff);

   assign rd_addr = cmd.scan_step ? scan_ptr_ff : head_ff;

   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem_ff[rd_addr];
      rd_data_ff <= data_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem_ff[tail_ff]  <= key_ff;
         data_mem_ff[tail_ff] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff       <= req_op;
         key_ff      <= req_in_key;
         data_ff     <= req_in_data;
         scan_ptr_ff <= next_slot(head_ff);
         left_ff     <= count_ff;
         dup_ff      <= 1'b0;
      end else if (cmd.scan_step) begin
         if (stat.scan_hit) begin
            dup_ff <= 1'b1;
         end else if (!stat.scan_end) begin
            left_ff     <= left_ff - 1'b1;
            scan_ptr_ff <= next_slot(scan_ptr_ff);
         end
      end
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      mem_we      = 1'b0;
      out_key_in  = '0;
      out_data_in = '0;
      if (op_ff) begin
         if (count_ff == '0) begin
            status_in = ukf_pkg::ST_UNDER;
         end else begin
            status_in   = ukf_pkg::ST_DEQ;
            out_key_in  = rd_key_ff;
            out_data_in = rd_data_ff;
            head_in     = next_slot(head_ff);
            count_in    = count_ff - 1'b1;
         end
      end else begin
         priority if (dup_ff) begin
            status_in = ukf_pkg::ST_DUP;
         end else if (count_ff == FULL_CNT) begin
            status_in = ukf_pkg::ST_OVER;
         end else begin
            status_in = ukf_pkg::ST_ENQ;
            mem_we    = cmd.finish;
            tail_in   = next_slot(tail_ff);
            count_in  = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.finish) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status    <= status_in;
         rsp_out_key   <= out_key_in;
         rsp_out_data  <= out_data_in;
         rsp_occupancy <= count_in;
         rsp_is_empty  <= (count_in == '0);
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ukf_checker.sv */
`default_nettype none

module ukf_checker #(
   parameter int DEPTH     = 16,
   parameter int KEY_BITS  = 16,
   parameter int DATA_BITS = 32
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [ukf_pkg::STATUS_BITS-1:0] rsp_status,
   input wire logic [KEY_BITS-1:0]             rsp_out_key,
   input wire logic [DATA_BITS-1:0]            rsp_out_data,
   input wire logic [$clog2(DEPTH+1)-1:0]      rsp_occupancy,
   input wire logic                            rsp_is_empty
);

   localparam logic [$clog2(DEPTH+1)-1:0] FULL_CNT = ($clog2(DEPTH+1))'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_key) && $stable(rsp_out_data) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_occupancy == '0))
      else $error("empty flag disagrees with occupancy");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ukf_pkg::ST_DEQ |-> rsp_out_key == '0 && rsp_out_data == '0)
      else $error("nonzero pair on a non-dequeue response");

   a_under_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ukf_pkg::ST_UNDER |-> rsp_is_empty)
      else $error("underflow reported on a nonempty queue");

   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ukf_pkg::ST_OVER |-> rsp_occupancy == FULL_CNT)
      else $error("overflow reported on a queue that is not full");

endmodule

bind unique_key_fifo ukf_checker #(
   .DEPTH     (DEPTH),
   .KEY_BITS  (KEY_BITS),
   .DATA_BITS (DATA_BITS)
) u_ukf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_out_key   (rsp_out_key),
   .rsp_out_data  (rsp_out_data),
   .rsp_occupancy (rsp_occupancy),
   .rsp_is_empty  (rsp_is_empty)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int DEPTH       = 16;
   localparam int KEY_BITS    = 16;
   localparam int DATA_BITS   = 32;
   localparam int OCC_BITS    = $clog2(DEPTH + 1);
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef struct {
      logic                 op;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] data;
   } fifo_req_type;

   typedef struct {
      logic [ukf_pkg::STATUS_BITS-1:0] status;
      logic [KEY_BITS-1:0]             key;
      logic [DATA_BITS-1:0]            data;
      logic [OCC_BITS-1:0]             occ;
      logic                            empty;
   } fifo_rsp_type;

   logic clock;
   logic reset = 1'b1;

   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   logic                            req_op      = 1'b0;
   logic        [KEY_BITS-1:0]      req_in_key  = '0;
   logic signed [DATA_BITS-1:0]     req_in_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   logic [ukf_pkg::STATUS_BITS-1:0] rsp_status;
   logic        [KEY_BITS-1:0]      rsp_out_key;
   logic signed [DATA_BITS-1:0]     rsp_out_data;
   logic [OCC_BITS-1:0]             rsp_occupancy;
   logic                            rsp_is_empty;

   // model of the queue contents
   logic [KEY_BITS-1:0]  key_mem  [DEPTH];
   logic [DATA_BITS-1:0] data_mem [DEPTH];
   int q_head  = 0;
   int q_tail  = 0;
   int q_count = 0;

   fifo_req_type req_backlog [$];
   fifo_rsp_type due_responses [$];
   fifo_req_type next_req;
   fifo_rsp_type oldest_due;

   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_start  = 1'b0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int errors        = 0;
   int reqs_accepted = 0;
   int status_seen [5] = '{default: 0};
   int full_seen     = 0;

   unique_key_fifo #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .DATA_BITS(DATA_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_in_key   (req_in_key),
      .req_in_data  (req_in_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_out_key  (rsp_out_key),
      .rsp_out_data (rsp_out_data),
      .rsp_occupancy(rsp_occupancy),
      .rsp_is_empty (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_responses.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic fifo_rsp_type predict_fifo_op(input logic op,
                                                    input logic [KEY_BITS-1:0] key,
                                                    input logic [DATA_BITS-1:0] data);
      fifo_rsp_type r;
      logic hit;
      int slot;
      r.status = ukf_pkg::ST_ENQ;
      r.key    = '0;
      r.data   = '0;
      hit      = 1'b0;
      slot     = q_head;
      for (int n = 0; n < q_count; n++) begin
         if (key_mem[slot] == key) hit = 1'b1;
         slot = (slot + 1) % DEPTH;
      end
      if (op == OP_ENQ) begin
         if (hit) begin
            r.status = ukf_pkg::ST_DUP;
         end else if (q_count == DEPTH) begin
            r.status = ukf_pkg::ST_OVER;
         end else begin
            key_mem[q_tail]  = key;
            data_mem[q_tail] = data;
            q_tail   = (q_tail + 1) % DEPTH;
            q_count++;
            r.status = ukf_pkg::ST_ENQ;
         end
      end else if (q_count == 0) begin
         r.status = ukf_pkg::ST_UNDER;
      end else begin
         r.key    = key_mem[q_head];
         r.data   = data_mem[q_head];
         q_head   = (q_head + 1) % DEPTH;
         q_count--;
         r.status = ukf_pkg::ST_DEQ;
      end
      r.occ   = OCC_BITS'(q_count);
      r.empty = (q_count == 0);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_valid   <= 1'b1;
            req_op      <= next_req.op;
            req_in_key  <= next_req.key;
            req_in_data <= next_req.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, with an optional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            due_responses.push_back(predict_fifo_op(req_op, req_in_key, req_in_data));
            reqs_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               $error("unexpected response: status %0d key %h", rsp_status, rsp_out_key);
               errors++;
            end else begin
               oldest_due = due_responses.pop_front();
               if (rsp_status !== oldest_due.status) begin
                  $error("status: expected %0d, got %0d", oldest_due.status, rsp_status);
                  errors++;
               end
               if (rsp_out_key !== oldest_due.key) begin
                  $error("out_key: expected %h, got %h", oldest_due.key, rsp_out_key);
                  errors++;
               end
               if (rsp_out_data !== oldest_due.data) begin
                  $error("out_data: expected %h, got %h", oldest_due.data, rsp_out_data);
                  errors++;
               end
               if (rsp_occupancy !== oldest_due.occ) begin
                  $error("occupancy: expected %0d, got %0d", oldest_due.occ, rsp_occupancy);
                  errors++;
               end
               if (rsp_is_empty !== oldest_due.empty) begin
                  $error("is_empty: expected %0d, got %0d", oldest_due.empty, rsp_is_empty);
                  errors++;
               end
               if (oldest_due.status <= ukf_pkg::ST_OVER) status_seen[oldest_due.status]++;
               if (oldest_due.occ == DEPTH) full_seen++;
            end
         end
      end
   end

   task automatic add_req(input logic op, input logic [KEY_BITS-1:0] key,
                          input logic [DATA_BITS-1:0] data);
      fifo_req_type r;
      r.op   = op;
      r.key  = key;
      r.data = data;
      req_backlog.push_back(r);
   endtask

   task automatic refresh_key_pool();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      if ($urandom_range(99) < 25) return KEY_BITS'($urandom);
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_data();
      case ($urandom_range(15))
         0:       return {1'b1, {(DATA_BITS-1){1'b0}}};
         1:       return {1'b0, {(DATA_BITS-1){1'b1}}};
         2:       return '1;
         3:       return '0;
         default: return DATA_BITS'($urandom);
      endcase
   endfunction

   // runs that fill, drain or churn the queue, plus some pure noise
   task automatic add_random_reqs(input int count);
      int made;
      int run_len;
      int enq_pct;
      made = 0;
      refresh_key_pool();
      while (made < count) begin
         run_len = $urandom_range(24, 4);
         case ($urandom_range(4))
            0, 1:    enq_pct = 85;
            2:       enq_pct = 20;
            3:       enq_pct = 55;
            default: enq_pct = $urandom_range(100);
         endcase
         repeat (run_len) begin
            add_req(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, pick_key(), pick_data());
            made++;
         end
      end
   endtask

   task automatic wait_quiet();
      while (req_backlog.size() != 0 || req_valid || due_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      @(negedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      add_random_reqs(count);
      wait_quiet();
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: underflow, fill to full with edge keys/data, dup vs overflow,
      // re-enqueue of a key that just left
      add_req(OP_DEQ, '0, '0);
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       add_req(OP_ENQ, '0, {1'b1, {(DATA_BITS-1){1'b0}}});
            1:       add_req(OP_ENQ, 16'h1111, {1'b0, {(DATA_BITS-1){1'b1}}});
            2:       add_req(OP_ENQ, 16'h2222, '1);
            3:       add_req(OP_ENQ, 16'h3333, '0);
            default: add_req(OP_ENQ, KEY_BITS'(i * 16'h1111), DATA_BITS'($urandom));
         endcase
      end
      add_req(OP_ENQ, '1, 32'h1234_5678);
      add_req(OP_ENQ, 16'h1234, 32'h1234_5678);
      add_req(OP_DEQ, '1, '1);
      add_req(OP_ENQ, '0, 32'h5a5a_a5a5);
      add_req(OP_ENQ, 16'h2222, '0);
      wait_quiet();

      // long receiver hold while the sender keeps pushing
      @(negedge clock);
      hold_start = 1'b1;
      refresh_key_pool();
      for (int i = 0; i < 40; i++)
         add_req(($urandom_range(99) < 80) ? OP_ENQ : OP_DEQ, pick_key(), pick_data());
      @(negedge clock);
      hold_start = 1'b0;
      wait_quiet();

      run_phase(0, 0, 350);
      run_phase(77, 0, 350);
      run_phase(0, 77, 350);
      run_phase(18, 18, 350);

      repeat (40) @(negedge clock);

      $display("%0d requests: %0d enqueued, %0d duplicate, %0d dequeued, %0d underflow,",
               reqs_accepted, status_seen[ukf_pkg::ST_ENQ], status_seen[ukf_pkg::ST_DUP],
               status_seen[ukf_pkg::ST_DEQ], status_seen[ukf_pkg::ST_UNDER]);
      $display("%0d overflow, %0d responses at full occupancy",
               status_seen[ukf_pkg::ST_OVER], full_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ukf_pkg.sv
rtl/core/ukf_ctrl.sv
rtl/core/ukf_dpath.sv
rtl/core/unique_key_fifo.sv
rtl/core/ukf_checker.sv
bench/testbench.sv
